FILE: hdl/mrmt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes for the memory region map table
// no dependencies; imported by every module of the block
package mrmt_pkg;

    // table geometry
    localparam int MAX_REGIONS = 16;
    localparam int TYPE_COUNT  = 7;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // field widths
    localparam int ADDR_W   = 64;
    localparam int TYPE_W   = 4;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // request codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SPLIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADARG   = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_NOREGION = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WR_ENTRY,
        S_WR_TAIL,
        S_WR_NEW,
        S_RESP
    } t_state;

    // how a requested range sits inside a holding entry
    typedef enum logic [2:0] {
        SH_EXACT,
        SH_FRONT,
        SH_MIDDLE,
        SH_BACK,
        SH_NONE
    } t_shape;

    typedef struct packed {
        logic                action;
        logic [ADDR_W-1:0]   base_address;
        logic [ADDR_W-1:0]   region_size;
        logic [TYPE_W-1:0]   region_type;
        logic [OWNER_W-1:0]  vm_id;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    // table entry: limit is base plus length, wrapped
    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   limit;
        logic [TYPE_W-1:0]   kind;
        logic [OWNER_W-1:0]  owner;
    } t_entry;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_W-1:0]    wr_idx;
        t_entry              wr_data;
        logic [IDX_W-1:0]    rd_idx;
    } t_mem_req;

    typedef struct packed {
        logic                conflict;
        logic                contain;
        t_shape              shape;
    } t_cmp_res;

endpackage

FILE: hdl/mrmt_store.sv
`timescale 1ns / 1ps
// entry store: one write port and one registered read port
// depends on mrmt_pkg
module mrmt_store
    import mrmt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [MAX_REGIONS];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/mrmt_cmp.sv
`timescale 1ns / 1ps
// shared range compare unit, applied to one table entry per cycle
// depends on mrmt_pkg
module mrmt_cmp
    import mrmt_pkg::*;
(
    input  logic [ADDR_W-1:0] i_req_base,
    input  logic [ADDR_W-1:0] i_req_limit,
    input  t_entry            i_entry,
    output t_cmp_res          o_res
);

    logic above_last;
    logic below_base;
    logic same_base;
    logic same_limit;
    logic inside_limit;

    // add overlap test; an entry whose limit wrapped to zero reaches the top
    assign above_last = (i_entry.limit != '0) && (i_req_base >= i_entry.limit);
    assign below_base = i_req_limit < i_entry.base;

    // split containment test
    assign same_base    = i_req_base == i_entry.base;
    assign same_limit   = i_req_limit == i_entry.limit;
    assign inside_limit = i_req_limit < i_entry.limit;

    always_comb begin
        o_res.conflict = !(above_last || below_base);
        o_res.contain  = !((i_req_base > i_entry.limit) || (i_req_base < i_entry.base)
                           || (i_req_limit > i_entry.limit));
        priority if (same_base && same_limit) begin
            o_res.shape = SH_EXACT;
        end else if (same_base && inside_limit) begin
            o_res.shape = SH_FRONT;
        end else if (!same_base && inside_limit) begin
            o_res.shape = SH_MIDDLE;
        end else if (!same_base && same_limit) begin
            o_res.shape = SH_BACK;
        end else begin
            o_res.shape = SH_NONE;
        end
    end

endmodule

FILE: hdl/mrmt_ctrl.sv
`timescale 1ns / 1ps
// sequencer: scans the table through the compare unit and writes back entries
// depends on mrmt_pkg; drives mrmt_store and reads mrmt_cmp results
module mrmt_ctrl
    import mrmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    output t_mem_req          o_mem_req,
    input  t_entry            i_rd_data,
    output logic [ADDR_W-1:0] o_req_base,
    output logic [ADDR_W-1:0] o_req_limit,
    input  t_cmp_res          i_cmp
);

    localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(MAX_REGIONS);
    localparam logic [CNT_W-1:0]    CNT_MAX2  = CNT_W'(MAX_REGIONS - 2);
    localparam logic [TYPE_W:0]     TYPE_LIM  = (TYPE_W + 1)'(TYPE_COUNT);

    t_state            r_state, n_state;
    t_status           r_status, n_status;
    t_in_item          r_req;
    logic [ADDR_W-1:0] r_req_limit;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_dv;
    logic [IDX_W-1:0]  r_didx;
    t_entry            r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    t_shape            r_shape;

    logic in_acc;
    logic bad_arg;
    logic is_add;
    logic scan_hit;
    logic scan_done;
    logic issue;
    logic free1;
    logic free2;

    assign in_acc  = i_in_valid && o_in_ready;
    assign bad_arg = (i_in_item.region_size == '0) || ({1'b0, i_in_item.region_type} >= TYPE_LIM);
    assign is_add  = r_req.action == ACT_ADD;

    // scan bookkeeping: one read issued per cycle until a hit, its data compared in the next cycle
    assign scan_hit  = (r_state == S_SCAN) && r_dv && (is_add ? i_cmp.conflict : i_cmp.contain);
    assign scan_done = (r_state == S_SCAN) && !r_dv && (r_idx >= r_count);
    assign issue     = (r_state == S_SCAN) && !scan_hit && (r_idx < r_count);
    assign free1     = r_count < CNT_MAX;
    assign free2     = r_count <= CNT_MAX2;

    assign o_req_base  = r_req.base_address;
    assign o_req_limit = r_req_limit;

    // next state and status
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state  = bad_arg ? S_RESP : S_SCAN;
                    n_status = bad_arg ? ST_BADARG : ST_OK;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    if (is_add) begin
                        n_state  = S_RESP;
                        n_status = ST_OVERLAP;
                    end else begin
                        unique case (i_cmp.shape)
                            SH_EXACT: n_state = S_WR_ENTRY;
                            SH_FRONT, SH_BACK: begin
                                n_state  = free1 ? S_WR_ENTRY : S_RESP;
                                n_status = free1 ? ST_OK : ST_FULL;
                            end
                            SH_MIDDLE: begin
                                n_state  = free2 ? S_WR_ENTRY : S_RESP;
                                n_status = free2 ? ST_OK : ST_FULL;
                            end
                            default: begin
                                n_state  = S_RESP;
                                n_status = ST_BADARG;
                            end
                        endcase
                    end
                end else if (scan_done) begin
                    if (is_add) begin
                        n_state  = free1 ? S_WR_NEW : S_RESP;
                        n_status = free1 ? ST_OK : ST_FULL;
                    end else begin
                        n_state  = S_RESP;
                        n_status = ST_NOREGION;
                    end
                end
            end
            S_WR_ENTRY: begin
                priority if (r_shape == SH_EXACT) begin
                    n_state = S_RESP;
                end else if (r_shape == SH_MIDDLE) begin
                    n_state = S_WR_TAIL;
                end else begin
                    n_state = S_WR_NEW;
                end
            end
            S_WR_TAIL: n_state = S_WR_NEW;
            S_WR_NEW:  n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake and store port
    always_comb begin
        o_in_ready         = r_state == S_IDLE;
        o_out_valid        = r_state == S_RESP;
        o_mem_req.wr_en    = 1'b0;
        o_mem_req.wr_idx   = r_count[IDX_W-1:0];
        o_mem_req.wr_data  = r_hit;
        o_mem_req.rd_idx   = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_WR_ENTRY: begin
                o_mem_req.wr_en  = 1'b1;
                o_mem_req.wr_idx = r_hit_idx;
                unique case (r_shape)
                    SH_EXACT:  o_mem_req.wr_data.kind  = r_req.region_type;
                    SH_FRONT:  o_mem_req.wr_data.base  = r_req_limit;
                    SH_MIDDLE, SH_BACK: o_mem_req.wr_data.limit = r_req.base_address;
                    default:   o_mem_req.wr_data = r_hit;
                endcase
            end
            S_WR_TAIL: begin
                o_mem_req.wr_en           = 1'b1;
                o_mem_req.wr_data.base    = r_req_limit;
            end
            S_WR_NEW: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_data = '{base:  r_req.base_address,
                                      limit: r_req_limit,
                                      kind:  r_req.region_type,
                                      owner: r_req.vm_id};
            end
            default: o_mem_req.wr_en = 1'b0;
        endcase
    end

    assign o_out_item.status      = r_status;
    assign o_out_item.entry_count = COUNT_W'(r_count);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_count  <= '0;
            r_idx    <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (in_acc) begin
                r_idx <= '0;
                r_dv  <= 1'b0;
            end else begin
                r_dv <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_state == S_WR_TAIL || r_state == S_WR_NEW) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // request and hit payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req       <= i_in_item;
            r_req_limit <= i_in_item.base_address + i_in_item.region_size;
        end
        r_didx <= r_idx[IDX_W-1:0];
        if (scan_hit) begin
            r_hit     <= i_rd_data;
            r_hit_idx <= r_didx;
            r_shape   <= i_cmp.shape;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count beyond table size");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> (r_state == S_WR_ENTRY || r_state == S_WR_TAIL
                             || r_state == S_WR_NEW))
        else $error("store written outside a write step");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_NEW || r_state == S_WR_TAIL) |-> (r_count < CNT_MAX))
        else $error("append with a full table");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_NEW) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance the count");

    a_good_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !bad_arg) |=> (r_state == S_SCAN && r_idx == '0 && !r_dv))
        else $error("scan did not start from the first entry");

endmodule

FILE: hdl/memory_region_map_table_core.sv
`timescale 1ns / 1ps
// Flow per item: a bad argument goes straight to the result. Otherwise the entries in use are
// scanned in order up to the first hit through the shared compare unit; an overlap, a full
// table or no holder ends in the result, a retype writes the entry back, a trim also appends the
// carved range, a middle cut writes the entry, its tail and the carved range, and an add with
// room appends it. Throughput: one item at a time, the next taken once the result is taken.
// Reset (synchronous, active low) empties the table and idles; stored entries are kept.
module memory_region_map_table_core
    import mrmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_mem_req          mem_req;
    t_entry            rd_data;
    t_cmp_res          cmp_res;
    logic [ADDR_W-1:0] req_base;
    logic [ADDR_W-1:0] req_limit;

    // sequencer
    mrmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_req_base  (req_base),
        .o_req_limit (req_limit),
        .i_cmp       (cmp_res)
    );

    // entry store
    mrmt_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // shared compare unit
    mrmt_cmp u_cmp (
        .i_req_base  (req_base),
        .i_req_limit (req_limit),
        .i_entry     (rd_data),
        .o_res       (cmp_res)
    );

endmodule

FILE: dv/mrmt_region_monitor.sv
`timescale 1ns / 1ps
// region map monitor: watches both item channels, predicts each result from its own
// copy of the region table and compares it with what the block returns; uses mrmt_pkg
module mrmt_region_monitor
    import mrmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending_count
);

    localparam int PRINT_CAP = 100;

    // shadow of the region table
    logic [ADDR_W-1:0]  tbl_base  [MAX_REGIONS];
    logic [ADDR_W-1:0]  tbl_len   [MAX_REGIONS];
    logic [TYPE_W-1:0]  tbl_kind  [MAX_REGIONS];
    logic [OWNER_W-1:0] tbl_owner [MAX_REGIONS];
    int                 tbl_used = 0;

    t_out_item expected_results[$];
    t_out_item oldest;
    int        fail_total   = 0;
    int        result_index = 0;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= PRINT_CAP) begin
            $display("[%0t] result %0d: %s", $time, result_index, what);
        end
    endtask

    function automatic void append_entry(input logic [ADDR_W-1:0] base,
                                         input logic [ADDR_W-1:0] len,
                                         input logic [TYPE_W-1:0] kind,
                                         input logic [OWNER_W-1:0] owner);
        if (tbl_used < MAX_REGIONS) begin
            tbl_base[tbl_used]  = base;
            tbl_len[tbl_used]   = len;
            tbl_kind[tbl_used]  = kind;
            tbl_owner[tbl_used] = owner;
            tbl_used++;
        end
    endfunction

    // add: any entry that is not wholly below or above conflicts, touching the start too
    function automatic t_status apply_add(input logic [ADDR_W-1:0] base,
                                          input logic [ADDR_W-1:0] size,
                                          input logic [TYPE_W-1:0] kind,
                                          input logic [OWNER_W-1:0] owner);
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] req_end;
        req_end = base + size;
        for (int i = 0; i < tbl_used; i++) begin
            last = tbl_base[i] + tbl_len[i] - 64'd1;
            if (!((base > last) || (req_end < tbl_base[i]))) begin
                return ST_OVERLAP;
            end
        end
        if (tbl_used >= MAX_REGIONS) begin
            return ST_FULL;
        end
        append_entry(base, size, kind, owner);
        return ST_OK;
    endfunction

    // split: first holding entry is retyped, or trimmed or cut with the carved range then appended
    function automatic t_status apply_split(input logic [ADDR_W-1:0] base,
                                            input logic [ADDR_W-1:0] size,
                                            input logic [TYPE_W-1:0] kind,
                                            input logic [OWNER_W-1:0] owner);
        logic [ADDR_W-1:0] carve_end;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
        int                free_slots;
        carve_end  = base + size;
        free_slots = MAX_REGIONS - tbl_used;
        for (int i = 0; i < tbl_used; i++) begin
            start = tbl_base[i];
            stop  = start + tbl_len[i];
            if ((base > stop) || (base < start) || (carve_end > stop)) begin
                continue;
            end
            if (base == start && carve_end == stop) begin
                tbl_kind[i] = kind;
                return ST_OK;
            end else if (base == start && carve_end < stop) begin
                if (free_slots < 1) begin
                    return ST_FULL;
                end
                tbl_base[i] = carve_end;
                tbl_len[i]  = tbl_len[i] - size;
            end else if (base > start && carve_end < stop) begin
                if (free_slots < 2) begin
                    return ST_FULL;
                end
                append_entry(carve_end, stop - carve_end, tbl_kind[i], tbl_owner[i]);
                tbl_len[i] = base - start;
            end else if (base > start && carve_end == stop) begin
                if (free_slots < 1) begin
                    return ST_FULL;
                end
                tbl_len[i] = tbl_len[i] - size;
            end else begin
                return ST_BADARG;
            end
            append_entry(base, size, kind, owner);
            return ST_OK;
        end
        return ST_NOREGION;
    endfunction

    function automatic t_out_item predict_region_op(input t_in_item item);
        t_status   st;
        t_out_item res;
        if (item.region_size == '0 || item.region_type >= TYPE_COUNT) begin
            st = ST_BADARG;
        end else if (item.action == ACT_ADD) begin
            st = apply_add(item.base_address, item.region_size, item.region_type, item.vm_id);
        end else begin
            st = apply_split(item.base_address, item.region_size, item.region_type,
                             item.vm_id);
        end
        res.status      = st;
        res.entry_count = COUNT_W'(tbl_used);
        return res;
    endfunction

    // results are checked before the item of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_used = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_out_item.status !== oldest.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_item.status, oldest.status));
                    end
                    if (i_out_item.entry_count !== oldest.entry_count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  i_out_item.entry_count,
                                                  oldest.entry_count));
                    end
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_region_op(i_in_item));
            end
        end
        o_pending_count <= expected_results.size();
        o_fail_count    <= fail_total;
    end

endmodule

FILE: dv/tb_memory_region_map_table_core.sv
`timescale 1ns / 1ps
// testbench top for memory_region_map_table_core: clock, reset, directed and random
// region requests with random idling on both channels; needs mrmt_pkg and mrmt_region_monitor
module tb_memory_region_map_table_core;
    import mrmt_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 450;
    localparam int CALM_TAIL_ITEMS = 60;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int KNOWN_DEPTH     = 64;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int idle_mode   = 1;
    bit calm_tail   = 1'b0;

    // ranges already requested, used to aim later requests at live entries
    logic [ADDR_W-1:0] known_base[$];
    logic [ADDR_W-1:0] known_size[$];

    always #(CLK_HALF_NS) clk = ~clk;

    memory_region_map_table_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    mrmt_region_monitor u_region_monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    function automatic t_in_item make_item(input logic act,
                                           input logic [ADDR_W-1:0] base,
                                           input logic [ADDR_W-1:0] size,
                                           input logic [TYPE_W-1:0] kind,
                                           input logic [OWNER_W-1:0] owner);
        t_in_item item;
        item.action       = act;
        item.base_address = base;
        item.region_size  = size;
        item.region_type  = kind;
        item.vm_id        = owner;
        return item;
    endfunction

    // mostly requests aimed at known ranges, plus fresh adds, noise and bad arguments
    function automatic t_in_item random_region_item();
        logic [ADDR_W-1:0]  kb;
        logic [ADDR_W-1:0]  ks;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  size;
        logic [TYPE_W-1:0]  kind;
        logic               act;
        int                 pick;
        int                 slot;
        pick = $urandom_range(0, 99);
        kb   = '0;
        ks   = '0;
        if (known_base.size() == 0) begin
            pick = 0;
        end else begin
            slot = $urandom_range(0, known_base.size() - 1);
            kb   = known_base[slot];
            ks   = known_size[slot];
        end
        kind = ($urandom_range(0, 99) < 88) ? TYPE_W'($urandom_range(0, TYPE_COUNT - 1))
                                            : TYPE_W'($urandom_range(TYPE_COUNT, 15));
        act  = ACT_ADD;
        if (pick < 10) begin
            // fresh add in a crowded window
            base = 64'h0000_0040_0000_0000 + (64'($urandom_range(0, 255)) << 12);
            size = 64'($urandom_range(1, 8)) << 12;
        end else if (pick < 14) begin
            // add at the top of the address space, may wrap
            base = ~64'd0 - (64'($urandom_range(0, 64)) << 12);
            size = 64'($urandom_range(1, 8)) << 12;
        end else if (pick < 28) begin
            // add landing inside a known range
            base = kb + (ks >> $urandom_range(1, 6));
            size = 64'($urandom_range(1, 4)) << 10;
        end else if (pick < 33) begin
            // add ending exactly at a known start
            size = 64'($urandom_range(1, 16)) << 8;
            base = kb - size;
        end else if (pick < 38) begin
            // add starting right after a known range
            base = kb + ks;
            size = 64'($urandom_range(1, 4)) << 8;
        end else if (pick < 68) begin
            // split shaped against a known range
            act = ACT_SPLIT;
            case ($urandom_range(0, 3))
                0: begin
                    base = kb;
                    size = ks;
                end
                1: begin
                    base = kb;
                    size = ks >> 1;
                end
                2: begin
                    base = kb + (ks >> 1);
                    size = ks - (ks >> 1);
                end
                default: begin
                    base = kb + (ks >> 2);
                    size = ks >> 2;
                end
            endcase
        end else if (pick < 78) begin
            // full-width noise
            act  = 1'($urandom_range(0, 1));
            base = {$urandom, $urandom};
            size = {$urandom, $urandom};
        end else if (pick < 88) begin
            // bad arguments on otherwise plausible ranges
            act  = 1'($urandom_range(0, 1));
            base = kb;
            if ($urandom_range(0, 1) == 0) begin
                size = '0;
            end else begin
                size = ks;
                kind = TYPE_W'($urandom_range(TYPE_COUNT, 15));
            end
        end else begin
            // retype an exact known range, still useful with a full table
            act  = ACT_SPLIT;
            base = kb;
            size = ks;
        end
        return make_item(act, base, size, kind, OWNER_W'($urandom_range(0, 255)));
    endfunction

    // hold the item until the block takes it
    task automatic issue_item(input t_in_item item);
        in_item  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (item.region_size != '0) begin
            known_base.push_back(item.base_address);
            known_size.push_back(item.region_size);
            if (known_base.size() > KNOWN_DEPTH) begin
                void'(known_base.pop_front());
                void'(known_size.pop_front());
            end
        end
    endtask

    task automatic sender_gap();
        if (!calm_tail && idle_mode != 0 &&
            $urandom_range(0, 99) < ((idle_mode == 1) ? 15 : 45)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // result side back-pressure in bursts
    initial begin
        @(posedge clk);
        forever begin
            if (!calm_tail && idle_mode != 0 &&
                $urandom_range(0, 99) < ((idle_mode == 1) ? 8 : 30)) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejected arguments and a split on an empty table
        issue_item(make_item(ACT_ADD, 64'h1000, 64'h0, 4'd0, 8'd0));
        issue_item(make_item(ACT_ADD, 64'h1000, 64'h1000, TYPE_W'(TYPE_COUNT), 8'd1));
        issue_item(make_item(ACT_SPLIT, 64'h1000, 64'h1000, 4'hF, 8'd2));
        issue_item(make_item(ACT_SPLIT, 64'h1000, 64'h100, 4'd1, 8'd3));
        // adds: plain, ending at an entry start, just past an entry, overlapping
        issue_item(make_item(ACT_ADD, 64'h1000, 64'h1000, 4'd0, 8'd0));
        issue_item(make_item(ACT_ADD, 64'h0, 64'h1000, 4'd1, 8'd0));
        issue_item(make_item(ACT_ADD, 64'h2000, 64'h100, 4'd6, 8'hFF));
        issue_item(make_item(ACT_ADD, 64'h1800, 64'h10, 4'd2, 8'd4));
        issue_item(make_item(ACT_ADD, 64'h2000, 64'h100, 4'd2, 8'd4));
        // splits: exact retype, front trim, back trim, middle cut, no holder
        issue_item(make_item(ACT_SPLIT, 64'h1000, 64'h1000, 4'd3, 8'd7));
        issue_item(make_item(ACT_SPLIT, 64'h1000, 64'h100, 4'd1, 8'd8));
        issue_item(make_item(ACT_SPLIT, 64'h1F00, 64'h100, 4'd2, 8'd9));
        issue_item(make_item(ACT_SPLIT, 64'h1400, 64'h100, 4'd4, 8'd10));
        issue_item(make_item(ACT_SPLIT, 64'h9000, 64'h10, 4'd5, 8'd11));
        // wrapping sums at the top of the address space
        issue_item(make_item(ACT_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 4'd5, 8'h80));
        issue_item(make_item(ACT_ADD, ~64'd0, ~64'd0, 4'd6, 8'hFF));
        issue_item(make_item(ACT_SPLIT, 64'hFFFF_FFFF_FFFF_F800, 64'h100, 4'd0, 8'h81));
        issue_item(make_item(ACT_SPLIT, 64'h1100, ~64'd0, 4'd3, 8'h55));
        issue_item(make_item(ACT_ADD, 64'h5555_5555_5555_5000, 64'h800, 4'd4, 8'hAA));
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                idle_mode <= $urandom_range(0, 2);
            end
            if (n == RANDOM_ITEMS - CALM_TAIL_ITEMS) begin
                calm_tail <= 1'b1;
            end
            if (n % 75 == 74) begin
                wait_for_results();
            end
            sender_gap();
            issue_item(random_region_item());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
